// File: src/fdre_pkg.sv
// Package for the flip-dot differential refresh encoder.
// Holds the shared widths, expander codes, drive tables and the controller state type.
// No dependencies.
package fdre_pkg;

  // Default panel geometry in pixels.
  localparam int unsigned DefWidth  = 112;
  localparam int unsigned DefHeight = 16;

  // Field widths.
  localparam int unsigned IdxW   = 8;
  localparam int unsigned DataW  = 8;
  localparam int unsigned XAddrW = 7;
  // Zero-extended index width. It covers the deepest shadow, 112 * 24 / 8 entries.
  localparam int unsigned IdxExtW = 9;
  // Row band within the display. At most 24 rows gives three bands.
  localparam int unsigned BandW = 2;
  // Row number, below 24.
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 7;

  // Geometry of one panel module.
  localparam int unsigned PanelCols = 28;
  localparam int unsigned CodeCols  = 7;
  localparam int unsigned RowSplit  = 14;

  // Expander bus addresses.
  localparam logic [XAddrW-1:0] ADDR_STROBE = 7'h20;
  localparam logic [XAddrW-1:0] ADDR_COLUMN = 7'h21;
  localparam logic [XAddrW-1:0] ADDR_ROW    = 7'h22;

  // Row driver enables.
  localparam logic [DataW-1:0] ROW_SET_LO = 8'h30;
  localparam logic [DataW-1:0] ROW_CLR_LO = 8'h28;
  localparam logic [DataW-1:0] ROW_SET_HI = 8'hC0;
  localparam logic [DataW-1:0] ROW_CLR_HI = 8'h88;

  // Strobe patterns. The bit of the addressed panel is flipped.
  localparam logic [DataW-1:0] STROBE_ON  = 8'hFF;
  localparam logic [DataW-1:0] STROBE_OFF = 8'h7F;
  localparam logic [DataW-1:0] DRIVER_OFF = 8'h00;
  localparam logic [DataW-1:0] SHADOW_RST = 8'hFF;

  // Order of the four writes for one dot.
  localparam logic [1:0] PH_ROW     = 2'd0;
  localparam logic [1:0] PH_COLUMN  = 2'd1;
  localparam logic [1:0] PH_STB_ON  = 2'd2;
  localparam logic [1:0] PH_STB_OFF = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_BITS,
    ST_EOF
  } state_e;

  // Row decoder code. Rows 13 and 27 use 0xFF.
  function automatic logic [DataW-1:0] row_code(input logic [RowW-1:0] row);
    logic [DataW-1:0] c;
    case (row)
      5'd0, 5'd14:  c = 8'h02;
      5'd1, 5'd15:  c = 8'h01;
      5'd2, 5'd16:  c = 8'h03;
      5'd3, 5'd17:  c = 8'h04;
      5'd4, 5'd18:  c = 8'h06;
      5'd5, 5'd19:  c = 8'h05;
      5'd6, 5'd20:  c = 8'h07;
      5'd7, 5'd21:  c = 8'h0A;
      5'd8, 5'd22:  c = 8'h09;
      5'd9, 5'd23:  c = 8'h0B;
      5'd10, 5'd24: c = 8'h0C;
      5'd11, 5'd25: c = 8'h0E;
      5'd12, 5'd26: c = 8'h0D;
      default:      c = 8'hFF;
    endcase
    return c;
  endfunction

  // Column decoder code within a group of seven, already shifted into place.
  function automatic logic [4:0] col_code(input logic [2:0] c7);
    logic [4:0] c;
    case (c7)
      3'd0:    c = 5'd16;
      3'd1:    c = 5'd8;
      3'd2:    c = 5'd24;
      3'd3:    c = 5'd4;
      3'd4:    c = 5'd20;
      3'd5:    c = 5'd12;
      default: c = 5'd28;
    endcase
    return c;
  endfunction

  // Column group select.
  function automatic logic [1:0] col_group(input logic [1:0] g);
    logic [1:0] c;
    case (g)
      2'd0:    c = 2'd0;
      2'd1:    c = 2'd2;
      2'd2:    c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

endpackage

// File: src/fdre_in_if.sv
// Request channel into the encoder. It carries one frame-buffer byte and its index.
// Depends on fdre_pkg.
interface fdre_in_if;
  import fdre_pkg::*;

  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  byte_index;
  logic [DataW-1:0] new_byte;
  logic             end_of_frame;

  modport source (output valid, byte_index, new_byte, end_of_frame, input ready);
  modport sink   (input valid, byte_index, new_byte, end_of_frame, output ready);
endinterface

// File: src/fdre_out_if.sv
// Request channel out of the encoder. It carries one port-expander write.
// Depends on fdre_pkg.
interface fdre_out_if;
  import fdre_pkg::*;

  logic              valid;
  logic              ready;
  logic [XAddrW-1:0] expander_addr;
  logic [DataW-1:0]  expander_data;
  logic              hold_after;
  logic              last;

  modport source (output valid, expander_addr, expander_data, hold_after, last, input ready);
  modport sink   (input valid, expander_addr, expander_data, hold_after, last, output ready);
endinterface

// File: src/fdre_ram.sv
// Generic single-port synchronous RAM with a registered read, one access per cycle.
// No dependencies.
module fdre_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 224,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/flipdot_diff_refresh_encoder.sv
// Top level of the flip-dot differential refresh encoder.
// Depends on fdre_pkg, fdre_in_if, fdre_out_if and fdre_ram.
//
// Usage:
//   in_i carries one frame-buffer byte per request: its index, its new value and
//   an end-of-frame flag. out_o carries port-expander writes, in the order the
//   panel must see them. The write that ends the results of a byte has last set.
//   A byte that differs from the shadow of the panel gives 32 writes: row, column,
//   strobe-on (with hold_after set) and strobe-off for each of its 8 dots. An
//   end-of-frame byte then adds three driver-off writes. An index beyond the
//   display is ignored, but its end-of-frame writes are still sent.
// Timing:
//   The shadow lives in a single-port RAM. It is read in the cycle that accepts a
//   request and is compared and written back in the next cycle. Writes then leave
//   at one per cycle through an output register. A request holds the block
//   through the shadow read and look, its dot writes if the byte changed and its
//   end-of-frame writes. The next request is taken once the last write is in the
//   output register. A stalled receiver holds the output register and the sequence.
// Reset:
//   After reset a clearing pass fills the shadow with 0xFF, one entry a cycle.
//   It covers all WIDTH*HEIGHT/8 entries (224 by default). in_i.ready stays low until
//   the pass is done.
module flipdot_diff_refresh_encoder #(
  parameter int unsigned WIDTH  = fdre_pkg::DefWidth,
  parameter int unsigned HEIGHT = fdre_pkg::DefHeight
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdre_in_if.sink    in_i,
  fdre_out_if.source out_o
);
  import fdre_pkg::*;

  localparam int unsigned DEPTH = (WIDTH * HEIGHT) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BANDS = HEIGHT / 8;

  state_e state_q, state_d;

  // Request held for the whole sequence.
  logic [IdxW-1:0]   idx_q;
  logic [DataW-1:0]  nb_q;
  logic              eof_q;
  logic [BandW-1:0]  band_q, band_d;
  logic [ColW-1:0]   col_q, col_d;

  // Column decode, worked out in the look cycle.
  logic [1:0]        panel_q, panel_d;
  logic [4:0]        colsel_q, colsel_d;

  // Write counter: dot in [4:2], write of that dot in [1:0].
  logic [4:0]        cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;

  // Output register.
  logic              ovalid_q, ovalid_d;
  logic [XAddrW-1:0] oaddr_q, oaddr_d;
  logic [DataW-1:0]  odata_q, odata_d;
  logic              ohold_q, ohold_d;
  logic              olast_q, olast_d;

  // Shadow RAM port.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DataW-1:0]  ram_wdata;
  logic [DataW-1:0]  ram_rdata;

  logic                in_acc;
  logic                out_free;
  logic                emit;
  logic                in_range;
  logic                changed;
  logic [IdxExtW-1:0]  in_idx_ext;
  logic [IdxExtW-1:0]  idx_ext;
  logic [IdxExtW-1:0]  col_full;
  logic [ColW-1:0]     c28;
  logic [2:0]          c7;
  logic [1:0]          grp;
  logic [2:0]          bit_sel;
  logic [1:0]          phase;
  logic                dot_set;
  logic [RowW-1:0]     row;
  logic [DataW-1:0]    code;
  logic [DataW-1:0]    row_en;
  logic [DataW-1:0]    panel_bit;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !ovalid_q || out_o.ready;
  assign in_idx_ext = {{(IdxExtW-IdxW){1'b0}}, in_i.byte_index};
  assign idx_ext    = {{(IdxExtW-IdxW){1'b0}}, idx_q};
  assign in_range   = idx_ext < IdxExtW'(DEPTH);
  assign changed    = in_range && (ram_rdata != nb_q);

  assign in_i.ready = (state_q == ST_IDLE);

  // Row band and column of an incoming index, from a few constant compares.
  always_comb begin
    band_d   = '0;
    col_full = in_idx_ext;
    for (int k = 1; k < BANDS; k++) begin
      if (in_idx_ext >= IdxExtW'(k * WIDTH)) begin
        band_d   = BandW'(k);
        col_full = in_idx_ext - IdxExtW'(k * WIDTH);
      end
    end
    col_d = col_full[ColW-1:0];
  end

  // Panel number, then position within the panel, split into seven-column groups.
  always_comb begin
    if (col_q >= ColW'(3 * PanelCols)) begin
      panel_d = 2'd3;
      c28     = col_q - ColW'(3 * PanelCols);
    end else if (col_q >= ColW'(2 * PanelCols)) begin
      panel_d = 2'd2;
      c28     = col_q - ColW'(2 * PanelCols);
    end else if (col_q >= ColW'(PanelCols)) begin
      panel_d = 2'd1;
      c28     = col_q - ColW'(PanelCols);
    end else begin
      panel_d = 2'd0;
      c28     = col_q;
    end
    if (c28 >= ColW'(3 * CodeCols)) begin
      grp = 2'd3;
      c7  = 3'(c28 - ColW'(3 * CodeCols));
    end else if (c28 >= ColW'(2 * CodeCols)) begin
      grp = 2'd2;
      c7  = 3'(c28 - ColW'(2 * CodeCols));
    end else if (c28 >= ColW'(CodeCols)) begin
      grp = 2'd1;
      c7  = 3'(c28 - ColW'(CodeCols));
    end else begin
      grp = 2'd0;
      c7  = c28[2:0];
    end
    colsel_d = col_code(c7) | {3'b000, col_group(grp)};
  end

  // Shadow RAM: clear pass, read on accept, write back in the look cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = in_idx_ext[AW-1:0];
    ram_wdata = nb_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = SHADOW_RST;
      end
      ST_LOOK: begin
        ram_we   = in_range;
        ram_addr = idx_ext[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fdre_ram #(
    .DATA_W (DataW),
    .DEPTH  (DEPTH)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (changed)    state_d = ST_BITS;
        else if (eof_q) state_d = ST_EOF;
        else            state_d = ST_IDLE;
      end
      ST_BITS: begin
        if (out_free && cnt_q == 5'd31) state_d = eof_q ? ST_EOF : ST_IDLE;
      end
      ST_EOF: begin
        if (out_free && cnt_q == 5'd2) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Dot drive bytes.
  assign bit_sel   = cnt_q[4:2];
  assign phase     = cnt_q[1:0];
  assign dot_set   = nb_q[bit_sel];
  assign row       = {band_q, bit_sel};
  assign code      = row_code(row);
  assign panel_bit = DataW'(1) << panel_q;

  always_comb begin
    if (row >= RowW'(RowSplit)) row_en = dot_set ? ROW_SET_HI : ROW_CLR_HI;
    else                        row_en = dot_set ? ROW_SET_LO : ROW_CLR_LO;
  end

  // Outputs: counters and the next expander write.
  always_comb begin
    emit    = 1'b0;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    oaddr_d = oaddr_q;
    odata_d = odata_q;
    ohold_d = ohold_q;
    olast_d = olast_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
      end
      ST_LOOK: begin
        cnt_d = '0;
      end
      ST_BITS: begin
        if (out_free) begin
          emit    = 1'b1;
          cnt_d   = cnt_q + 5'd1;
          ohold_d = 1'b0;
          olast_d = (cnt_q == 5'd31) && !eof_q;
          case (phase)
            PH_ROW: begin
              oaddr_d = ADDR_ROW;
              odata_d = row_en | {5'b00000, code[3], code[1:0]};
            end
            PH_COLUMN: begin
              oaddr_d = ADDR_COLUMN;
              odata_d = {code[2], !dot_set, colsel_q, 1'b0};
            end
            PH_STB_ON: begin
              oaddr_d = ADDR_STROBE;
              odata_d = STROBE_ON ^ panel_bit;
              ohold_d = 1'b1;
            end
            default: begin
              oaddr_d = ADDR_STROBE;
              odata_d = STROBE_OFF ^ panel_bit;
            end
          endcase
          if (cnt_q == 5'd31) cnt_d = '0;
        end
      end
      ST_EOF: begin
        if (out_free) begin
          emit    = 1'b1;
          cnt_d   = cnt_q + 5'd1;
          odata_d = DRIVER_OFF;
          ohold_d = 1'b0;
          olast_d = (cnt_q == 5'd2);
          case (cnt_q[1:0])
            2'd0:    oaddr_d = ADDR_STROBE;
            2'd1:    oaddr_d = ADDR_COLUMN;
            default: oaddr_d = ADDR_ROW;
          endcase
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit)             ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
    else                  ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= in_i.byte_index;
      nb_q   <= in_i.new_byte;
      eof_q  <= in_i.end_of_frame;
      band_q <= band_d;
      col_q  <= col_d;
    end
    if (state_q == ST_LOOK) begin
      panel_q  <= panel_d;
      colsel_q <= colsel_d;
    end
    oaddr_q <= oaddr_d;
    odata_q <= odata_d;
    ohold_q <= ohold_d;
    olast_q <= olast_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.expander_addr = oaddr_q;
  assign out_o.expander_data = odata_q;
  assign out_o.hold_after    = ohold_q;
  assign out_o.last          = olast_q;

endmodule

// File: tb/flipdot_diff_refresh_encoder_test.sv
`timescale 1ns / 100ps
// Testbench for flipdot_diff_refresh_encoder. It drives frame-buffer bytes, predicts
// the expander writes from its own copy of the panel image and checks every write.
// Depends on fdre_pkg, fdre_in_if, fdre_out_if and the encoder RTL.
module flipdot_diff_refresh_encoder_test;
  import fdre_pkg::*;

  // Geometry under test. The shadow holds one byte per column per 8-row band.
  localparam int unsigned WIDTH        = 112;
  localparam int unsigned HEIGHT       = 16;
  localparam int unsigned SHADOW_DEPTH = WIDTH * HEIGHT / 8;
  localparam int unsigned MAX_WRITES   = 35;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RAND_ITEMS   = 360;

  // Idle profiles: which side of the link holds back, in percent of cycles.
  typedef enum logic [1:0] {
    IDLE_RX_HEAVY,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    logic             eof;
    idle_mode_e       mode;
  } frame_byte_t;

  typedef struct packed {
    logic [XAddrW-1:0] addr;
    logic [DataW-1:0]  data;
    logic              hold;
    logic              last;
  } expander_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fdre_in_if  in_bus ();
  fdre_out_if out_bus ();

  flipdot_diff_refresh_encoder #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  frame_byte_t     frame_bytes[$];      // requests still to be driven
  expander_write_t expected_writes[$];  // writes predicted, not yet seen
  logic [DataW-1:0] panel_image[SHADOW_DEPTH];  // what the panel shows, per predictor
  logic [DataW-1:0] planned_image[SHADOW_DEPTH]; // same, as seen while building stimulus
  expander_write_t  dot_writes[MAX_WRITES];
  int               dot_write_cnt;
  idle_mode_e       idle_mode = IDLE_RX_HEAVY;
  logic             req_taken = 1'b0;
  int               err_count = 0;

  // Sender idles more in the first profile's mirror image, receiver the other way.
  function automatic int tx_idle_pct(input idle_mode_e m);
    case (m)
      IDLE_RX_HEAVY: return 32;
      IDLE_TX_HEAVY: return 53;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(input idle_mode_e m);
    case (m)
      IDLE_RX_HEAVY: return 53;
      IDLE_TX_HEAVY: return 32;
      default:       return 0;
    endcase
  endfunction

  // Row decoder drive code; the pattern repeats every 14 rows, the 14th row
  // of each half uses the all-ones entry.
  function automatic logic [7:0] row_decode(input int row);
    case (row % 14)
      0:       return 8'h02;
      1:       return 8'h01;
      2:       return 8'h03;
      3:       return 8'h04;
      4:       return 8'h06;
      5:       return 8'h05;
      6:       return 8'h07;
      7:       return 8'h0A;
      8:       return 8'h09;
      9:       return 8'h0B;
      10:      return 8'h0C;
      11:      return 8'h0E;
      12:      return 8'h0D;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic add_write(input logic [XAddrW-1:0] addr, input logic [DataW-1:0] data,
                           input logic hold);
    dot_writes[dot_write_cnt] = {addr, data, hold, 1'b0};
    dot_write_cnt++;
  endtask

  // Works out the expander writes one accepted byte causes and updates the image.
  task automatic predict_writes(input logic [IdxW-1:0] idx, input logic [DataW-1:0] nb,
                                input logic eof);
    int pos, col, row, c28, panel, b, i;
    logic [7:0] code;
    logic [2:0] sel;
    logic [1:0] grp;
    logic       s;
    expander_write_t w;
    dot_write_cnt = 0;
    pos = int'(idx);
    if (pos < SHADOW_DEPTH) begin
      col   = pos % WIDTH;
      c28   = col % 28;
      panel = col / 28;
      grp   = 2'(c28 / 7);
      sel   = 3'(c28 % 7 + 1);  // column code is this value with its bits reversed
      if (panel_image[pos] != nb) begin
        for (b = 0; b < 8; b++) begin
          row  = 8 * (pos / WIDTH) + b;
          code = row_decode(row);
          s    = nb[b];
          add_write(ADDR_ROW,
                    (s ? (row >= 14 ? ROW_SET_HI : ROW_SET_LO)
                       : (row >= 14 ? ROW_CLR_HI : ROW_CLR_LO))
                    | {5'b0, code[3], code[1:0]}, 1'b0);
          add_write(ADDR_COLUMN,
                    {code[2], ~s, sel[0], sel[1], sel[2], grp[0], grp[1], 1'b0}, 1'b0);
          add_write(ADDR_STROBE, STROBE_ON ^ (8'd1 << panel), 1'b1);
          add_write(ADDR_STROBE, STROBE_OFF ^ (8'd1 << panel), 1'b0);
        end
      end
      panel_image[pos] = nb;
    end
    if (eof) begin
      add_write(ADDR_STROBE, DRIVER_OFF, 1'b0);
      add_write(ADDR_COLUMN, DRIVER_OFF, 1'b0);
      add_write(ADDR_ROW, DRIVER_OFF, 1'b0);
    end
    for (i = 0; i < dot_write_cnt; i++) begin
      w      = dot_writes[i];
      w.last = (i == dot_write_cnt - 1);
      expected_writes.push_back(w);
    end
  endtask

  task automatic queue_byte(input int idx, input int data, input logic eof,
                            input idle_mode_e m);
    frame_byte_t fb;
    fb.idx  = IdxW'(idx);
    fb.data = DataW'(data);
    fb.eof  = eof;
    fb.mode = m;
    frame_bytes.push_back(fb);
    if (idx < SHADOW_DEPTH) planned_image[idx] = DataW'(data);
  endtask

  // Random part: mostly refresh passes over runs of adjacent bytes ending in
  // end-of-frame, with stray single bytes (some off the display) mixed in.
  task automatic build_random;
    int n, len, start, k, idx, data;
    idle_mode_e m;
    n = 0;
    while (n < RAND_ITEMS) begin
      m = (n < RAND_ITEMS / 3) ? IDLE_RX_HEAVY :
          (n < 2 * RAND_ITEMS / 3) ? IDLE_TX_HEAVY : IDLE_NONE;
      if ($urandom_range(99) < 75) begin
        len   = $urandom_range(10, 3);
        start = $urandom_range(SHADOW_DEPTH - 1);
        for (k = 0; k < len; k++) begin
          idx  = (start + k) % SHADOW_DEPTH;
          data = ($urandom_range(99) < 20) ? planned_image[idx] : $urandom_range(255);
          queue_byte(idx, data, k == len - 1, m);
        end
        n += len;
      end else begin
        if ($urandom_range(99) < 35) idx = $urandom_range(255, SHADOW_DEPTH);
        else idx = $urandom_range(SHADOW_DEPTH - 1);
        data = $urandom_range(255);
        queue_byte(idx, data, 1'($urandom_range(1)), m);
        n++;
      end
    end
  endtask

  // Driver: requests change on the falling edge only.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || req_taken) begin
      req_taken = 1'b0;
      if (frame_bytes.size() != 0 &&
          $urandom_range(99) >= tx_idle_pct(frame_bytes[0].mode)) begin
        idle_mode               = frame_bytes[0].mode;
        in_bus.byte_index      <= frame_bytes[0].idx;
        in_bus.new_byte        <= frame_bytes[0].data;
        in_bus.end_of_frame    <= frame_bytes[0].eof;
        in_bus.valid           <= 1'b1;
        void'(frame_bytes.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure follows the active idle profile.
  always @(negedge clk_i) begin
    out_bus.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct(idle_mode));
  end

  // Monitor: predict on each accepted request, check each accepted write.
  always @(posedge clk_i) begin
    expander_write_t w;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_writes(in_bus.byte_index, in_bus.new_byte, in_bus.end_of_frame);
        req_taken = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected expander write: addr %0h data %0h",
                 out_bus.expander_addr, out_bus.expander_data);
          err_count++;
        end else begin
          w = expected_writes.pop_front();
          if (out_bus.expander_addr !== w.addr) begin
            $error("expander_addr: expected %0h, actual %0h", w.addr, out_bus.expander_addr);
            err_count++;
          end
          if (out_bus.expander_data !== w.data) begin
            $error("expander_data: expected %0h, actual %0h", w.data, out_bus.expander_data);
            err_count++;
          end
          if (out_bus.hold_after !== w.hold) begin
            $error("hold_after: expected %0b, actual %0b", w.hold, out_bus.hold_after);
            err_count++;
          end
          if (out_bus.last !== w.last) begin
            $error("last: expected %0b, actual %0b", w.last, out_bus.last);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.byte_index   = '0;
    in_bus.new_byte     = '0;
    in_bus.end_of_frame = 1'b0;
    out_bus.ready       = 1'b0;
    for (int i = 0; i < SHADOW_DEPTH; i++) begin
      panel_image[i]   = SHADOW_RST;
      planned_image[i] = SHADOW_RST;
    end

    // Directed: first change, repeats that must stay silent, end of frame alone,
    // band edges (rows 13, 14, 15 sit in the upper band), every panel boundary,
    // the last index and indexes past the display.
    queue_byte(0, 8'h00, 1'b0, IDLE_RX_HEAVY);
    queue_byte(0, 8'h00, 1'b0, IDLE_RX_HEAVY);
    queue_byte(0, 8'h00, 1'b1, IDLE_RX_HEAVY);
    queue_byte(5, 8'hFF, 1'b0, IDLE_RX_HEAVY);
    queue_byte(111, 8'hA5, 1'b0, IDLE_RX_HEAVY);
    queue_byte(112, 8'h5A, 1'b0, IDLE_RX_HEAVY);
    queue_byte(112, 8'hA5, 1'b1, IDLE_RX_HEAVY);
    queue_byte(223, 8'h00, 1'b1, IDLE_RX_HEAVY);
    queue_byte(224, 8'h3C, 1'b0, IDLE_RX_HEAVY);
    queue_byte(255, 8'hC3, 1'b1, IDLE_RX_HEAVY);
    queue_byte(27, 8'h81, 1'b0, IDLE_RX_HEAVY);
    queue_byte(28, 8'h7E, 1'b0, IDLE_RX_HEAVY);
    queue_byte(55, 8'h0F, 1'b0, IDLE_RX_HEAVY);
    queue_byte(56, 8'hF0, 1'b0, IDLE_RX_HEAVY);
    queue_byte(83, 8'h33, 1'b0, IDLE_RX_HEAVY);
    queue_byte(84, 8'hCC, 1'b0, IDLE_RX_HEAVY);
    queue_byte(139, 8'h55, 1'b0, IDLE_RX_HEAVY);
    queue_byte(195, 8'hAA, 1'b0, IDLE_RX_HEAVY);
    queue_byte(6, 8'h01, 1'b0, IDLE_RX_HEAVY);
    queue_byte(13, 8'h80, 1'b0, IDLE_RX_HEAVY);
    queue_byte(20, 8'hFE, 1'b0, IDLE_RX_HEAVY);
    queue_byte(0, 8'hFF, 1'b0, IDLE_RX_HEAVY);
    queue_byte(223, 8'hFF, 1'b1, IDLE_RX_HEAVY);
    build_random();

    // Reset, then the block clears its shadow before taking requests.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (frame_bytes.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
src/fdre_pkg.sv
src/fdre_in_if.sv
src/fdre_out_if.sv
src/fdre_ram.sv
src/flipdot_diff_refresh_encoder.sv
tb/flipdot_diff_refresh_encoder_test.sv
